// ===== src/pip_pkg.sv =====
package pip_pkg;

  // Command codes carried by the cmd field
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } pip_state_t;

  // Tag that travels with each memory read down the edge pipeline
  typedef struct packed {
    logic valid;     // a read was issued for this query
    logic has_edge;  // read closes an edge with the previous vertex
    logic last;      // final read of the query
  } pip_tag_t;

endpackage

// ===== src/pip_vertex_mem.sv =====
module pip_vertex_mem import pip_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int CW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [CW-1:0] wr_x,
  input  logic [CW-1:0] wr_y,
  input  logic [AW-1:0] rd_addr,
  output logic [CW-1:0] rd_x,
  output logic [CW-1:0] rd_y
);

  logic [CW-1:0] mem_x [DEPTH];
  logic [CW-1:0] mem_y [DEPTH];

  // Store one vertex
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
    end
  end

  // Read one vertex through registered outputs
  always_ff @(posedge clk) begin
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

endmodule

// ===== src/pip_edge_pipe.sv =====
module pip_edge_pipe import pip_pkg::*; #(
  parameter int EW = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic signed [EW-1:0] px,
  input  logic signed [EW-1:0] py,
  input  pip_tag_t             tag_in,
  input  logic signed [EW-1:0] rd_x,
  input  logic signed [EW-1:0] rd_y,
  output logic                 done,
  output logic                 inside_res
);

  localparam int DW = EW + 1;
  localparam int PW = 2 * DW;

  pip_tag_t tag1, tag2, tag3;

  logic signed [EW-1:0] x1, y1;

  logic                 a_ok, a_vert, a_dyneg;
  logic signed [DW-1:0] a_dy, a_dxp, a_dyp, a_dx;

  logic                 b_ok, b_vert, b_dyneg;
  logic signed [PW-1:0] b_lhs, b_rhs;

  logic parity;
  logic cross_ok, toggle;

  logic                 span_ok;
  logic signed [DW-1:0] x1_w, y1_w, x2_w, y2_w, px_w, py_w;

  // Widen operands so that differences are exact
  assign x1_w = DW'(x1);
  assign y1_w = DW'(y1);
  assign x2_w = DW'(rd_x);
  assign y2_w = DW'(rd_y);
  assign px_w = DW'(px);
  assign py_w = DW'(py);

  // Point y in (min y, max y], point x at most max x, edge not horizontal
  assign span_ok = ((y1 < py) || (rd_y < py)) &&
                   ((y1 >= py) || (rd_y >= py)) &&
                   ((x1 >= px) || (rd_x >= px)) &&
                   (y1 != rd_y);

  // Advance tags through the read and arithmetic stages
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      tag3 <= '0;
    end else begin
      tag1 <= tag_in;
      tag2 <= tag1;
      tag3 <= tag2;
    end
  end

  // Hold previous vertex and form differences and range flags
  always_ff @(posedge clk) begin
    if (tag1.valid) begin
      x1      <= rd_x;
      y1      <= rd_y;
      a_ok    <= span_ok;
      a_vert  <= (x1 == rd_x);
      a_dy    <= y2_w - y1_w;
      a_dxp   <= px_w - x1_w;
      a_dyp   <= py_w - y1_w;
      a_dx    <= x2_w - x1_w;
      a_dyneg <= (rd_y < y1);
    end
  end

  // Cross-multiply
  always_ff @(posedge clk) begin
    if (tag2.valid) begin
      b_ok    <= a_ok;
      b_vert  <= a_vert;
      b_dyneg <= a_dyneg;
      b_lhs   <= PW'(a_dxp) * PW'(a_dy);
      b_rhs   <= PW'(a_dyp) * PW'(a_dx);
    end
  end

  // Crossing test, sign-corrected by the direction of the edge
  assign cross_ok = b_dyneg ? (b_rhs <= b_lhs) : (b_lhs <= b_rhs);
  assign toggle   = tag3.valid && tag3.has_edge && b_ok && (b_vert || cross_ok);

  // Accumulate parity and report at the end of the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      parity <= 1'b0;
      done   <= 1'b0;
    end else begin
      if (clear) begin
        parity <= 1'b0;
      end else begin
        parity <= parity ^ toggle;
      end
      done <= tag3.valid && tag3.last;
    end
  end

  always_ff @(posedge clk) begin
    if (tag3.valid && tag3.last) begin
      inside_res <= parity ^ toggle;
    end
  end

endmodule

// ===== src/point_in_polygon_test_unit.sv =====
// Ray-casting point-in-polygon unit. An item with cmd = write stores one vertex
// in a single cycle; busy stays low. An item with cmd = query reads the vertex
// store once per cycle, vertex 0 first and vertex 0 again at the end to close
// the polygon, so a query holds busy high for about vertex_count + 5 cycles:
// one memory read port fetches one vertex per cycle, followed by a four-stage
// edge pipeline (read, differences, cross-multiply, compare). The result
// appears on inside_res for exactly one cycle with done high and must be taken
// then. vertex_count is written through the cfg channel while the unit is idle;
// counts above MAX_VERTICES act as MAX_VERTICES and zero reports outside.
// Every vertex used by a query must have been written before.
module point_in_polygon_test_unit import pip_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [5:0]  vertex_index,
  input  logic [31:0] coord_x,
  input  logic [31:0] coord_y,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  vertex_count,
  output logic        done,
  output logic        inside_res
);

  localparam int EW    = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  pip_state_t state, state_next;

  logic [6:0]       count_cfg;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] n_eff, n_sat;

  logic signed [EW-1:0] px, py;
  logic signed [EW-1:0] in_x, in_y;

  logic                   accept, wr_en, query_go, clear;
  logic [AW-1:0]          rd_addr;
  logic [COORD_WIDTH-1:0] wr_x, wr_y, rd_x, rd_y;
  pip_tag_t               tag;
  logic                   pipe_done;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign wr_en     = accept && (cmd == CMD_WRITE) && (32'(vertex_index) < 32'(MAX_VERTICES));
  assign query_go  = accept && (cmd == CMD_QUERY);
  assign clear     = query_go;

  // Wrap inputs to the coordinate width
  assign in_x = coord_x[EW-1:0];
  assign in_y = coord_y[EW-1:0];
  assign wr_x = COORD_WIDTH'(in_x);
  assign wr_y = COORD_WIDTH'(in_y);

  // Saturate the vertex count
  assign n_sat = (32'(count_cfg) > 32'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                       : CNT_W'(count_cfg);

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      count_cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      count_cfg <= vertex_count;
    end
  end

  // Latch the query point and count
  always_ff @(posedge clk) begin
    if (query_go) begin
      px    <= in_x;
      py    <= in_y;
      n_eff <= n_sat;
    end
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Walk the vertices, then wait for the pipeline to finish
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    tag        = '0;
    rd_addr    = (cnt == n_eff) ? '0 : cnt[AW-1:0];
    unique case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (query_go) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        tag.valid    = 1'b1;
        tag.has_edge = (cnt != '0);
        tag.last     = (cnt == n_eff);
        if (cnt == n_eff) begin
          state_next = ST_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (pipe_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  pip_vertex_mem #(
    .DEPTH (MAX_VERTICES),
    .AW    (AW),
    .CW    (COORD_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(vertex_index)),
    .wr_x    (wr_x),
    .wr_y    (wr_y),
    .rd_addr (rd_addr),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  pip_edge_pipe #(
    .EW (EW)
  ) u_pipe (
    .clk        (clk),
    .rst        (rst),
    .clear      (clear),
    .px         (px),
    .py         (py),
    .tag_in     (tag),
    .rd_x       (rd_x[EW-1:0]),
    .rd_y       (rd_y[EW-1:0]),
    .done       (pipe_done),
    .inside_res (inside_res)
  );

  assign done = pipe_done;

endmodule

// ===== tb/point_in_polygon_test_unit_tb.sv =====
`timescale 1ns / 100ps

module point_in_polygon_test_unit_tb import pip_pkg::*;;

  localparam int NUM_SLOTS = 64;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_WAIT = 20;
  localparam logic signed [31:0] UNIT = 32'sh0001_0000;

  typedef struct {
    logic        cmd;
    logic [5:0]  slot;
    logic [31:0] x;
    logic [31:0] y;
  } vertex_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        cmd = CMD_WRITE;
  logic [5:0]  vertex_index = '0;
  logic [31:0] coord_x = '0;
  logic [31:0] coord_y = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  vertex_count = '0;
  logic        done;
  logic        inside_res;

  vertex_item_t pending_items[$];
  vertex_item_t next_item;
  logic         expected_inside[$];
  int           sender_idle_pct = 0;
  int           items_queued = 0;
  int           items_taken = 0;
  int           failures = 0;
  int           quiet_cycles = 0;

  // Polygon as the block should hold it
  logic signed [31:0] vert_x[NUM_SLOTS];
  logic signed [31:0] vert_y[NUM_SLOTS];
  logic [6:0]         model_count = '0;

  // Polygon as planned by the stimulus, used to keep queries on written slots
  logic signed [31:0]   plan_x[NUM_SLOTS];
  logic signed [31:0]   plan_y[NUM_SLOTS];
  logic [NUM_SLOTS-1:0] plan_written = '0;

  point_in_polygon_test_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .vertex_index (vertex_index),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .vertex_count (vertex_count),
    .done         (done),
    .inside_res   (inside_res)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Does the ray from (px, py) towards +x cross the edge (x1, y1) -> (x2, y2)?
  function automatic logic edge_crosses(input logic signed [31:0] px, py, x1, y1, x2, y2);
    logic signed [31:0] lo_y, hi_y, hi_x;
    logic signed [32:0] dx_pt, dy_pt, dx_edge, dy_edge;
    logic signed [65:0] lhs, rhs;
    lo_y = (y1 < y2) ? y1 : y2;
    hi_y = (y1 < y2) ? y2 : y1;
    hi_x = (x1 < x2) ? x2 : x1;
    if (!(lo_y < py) || hi_y < py || hi_x < px || y1 == y2)
      return 1'b0;
    if (x1 == x2)
      return 1'b1;
    dx_pt = px - x1;
    dy_pt = py - y1;
    dx_edge = x2 - x1;
    dy_edge = y2 - y1;
    // Compare px against the crossing without dividing; flip for a falling edge
    lhs = dx_pt * dy_edge;
    rhs = dy_pt * dx_edge;
    if (dy_edge < 0)
      return rhs <= lhs;
    return lhs <= rhs;
  endfunction

  // Walk every edge of the polygon in use, closing back to vertex 0
  function automatic logic predict_inside(input logic signed [31:0] px, py);
    int n;
    int j;
    logic flag;
    logic signed [31:0] ax, ay;
    n = (model_count > NUM_SLOTS) ? NUM_SLOTS : model_count;
    flag = 1'b0;
    if (n == 0)
      return 1'b0;
    ax = vert_x[0];
    ay = vert_y[0];
    for (int i = 1; i <= n; i++) begin
      j = (i == n) ? 0 : i;
      if (edge_crosses(px, py, ax, ay, vert_x[j], vert_y[j]))
        flag = ~flag;
      ax = vert_x[j];
      ay = vert_y[j];
    end
    return flag;
  endfunction

  // Mix of full-range, extreme, coarse-grid and small fractional coordinates
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0: return $urandom();
      1: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      2, 3, 4: return ($urandom_range(8) - 4) << 16;
      default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  // Query coordinate, often snapped onto or next to a vertex in use
  function automatic logic [31:0] query_coord(input bit want_x, input int span);
    int unsigned s;
    if (span > 0 && $urandom_range(9) < 4) begin
      s = $urandom_range(span - 1);
      return (want_x ? plan_x[s] : plan_y[s]) + $urandom_range(2) - 1;
    end
    return rand_coord();
  endfunction

  task automatic queue_write(input logic [5:0] slot, input logic [31:0] x, y);
    vertex_item_t item;
    item = '{CMD_WRITE, slot, x, y};
    pending_items = {pending_items, item};
    plan_x[slot] = x;
    plan_y[slot] = y;
    plan_written[slot] = 1'b1;
    items_queued++;
  endtask

  task automatic queue_query(input logic [31:0] x, y);
    vertex_item_t item;
    item = '{CMD_QUERY, 6'($urandom_range(NUM_SLOTS - 1)), x, y};
    pending_items = {pending_items, item};
    items_queued++;
  endtask

  // Hold until every queued item is taken and every result is back
  task automatic wait_idle();
    while (items_taken != items_queued || expected_inside.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(input logic [6:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    vertex_count <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic begin_phase(input logic [6:0] count, input int idle_pct);
    wait_idle();
    sender_idle_pct = idle_pct;
    set_vertex_count(count);
  endtask

  // Build a polygon for the slots in use, then mostly queries against it
  task automatic run_phase(input logic [6:0] count, input int idle_pct, input int n_items);
    int span;
    bit fresh;
    span = (count > NUM_SLOTS) ? NUM_SLOTS : count;
    fresh = $urandom_range(1);
    begin_phase(count, idle_pct);
    for (int s = 0; s < span; s++)
      if (fresh || !plan_written[s])
        queue_write(6'(s), rand_coord(), rand_coord());
    repeat (n_items) begin
      if ($urandom_range(4) == 0)
        queue_write(6'($urandom_range(NUM_SLOTS - 1)), rand_coord(), rand_coord());
      else
        queue_query(query_coord(1'b1, span), query_coord(1'b0, span));
    end
  endtask

  // Drive items from the queue, idling at random
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_item = pending_items.pop_front();
        start <= 1'b1;
        cmd <= next_item.cmd;
        vertex_index <= next_item.slot;
        coord_x <= next_item.x;
        coord_y <= next_item.y;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Track accepted items and check each result against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      model_count = '0;
      expected_inside.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        model_count = vertex_count;
      if (start && !busy) begin
        items_taken++;
        if (cmd == CMD_WRITE) begin
          vert_x[vertex_index] = coord_x;
          vert_y[vertex_index] = coord_y;
        end else begin
          expected_inside = {expected_inside, predict_inside(coord_x, coord_y)};
        end
      end
      if (done) begin
        if (expected_inside.size() == 0) begin
          $display("%0t: unexpected result inside_res=%0b", $time, inside_res);
          failures++;
        end else if (inside_res !== expected_inside[0]) begin
          $display("%0t: inside_res expected %0b, got %0b", $time, expected_inside[0],
                   inside_res);
          failures++;
          void'(expected_inside.pop_front());
        end else begin
          void'(expected_inside.pop_front());
        end
      end
    end
  end

  // Stop a run that makes no progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Zero count from reset reports outside; load a square meanwhile
    queue_query(32'h7FFF_FFFF, 32'h8000_0000);
    queue_write(6'd0, -10 * UNIT, -10 * UNIT);
    queue_write(6'd1, 10 * UNIT, -10 * UNIT);
    queue_write(6'd2, 10 * UNIT, 10 * UNIT);
    queue_write(6'd3, -10 * UNIT, 10 * UNIT);
    queue_query(32'h0, 32'h0);

    // Square: center, outside, on edges, on a corner, extreme points
    begin_phase(7'd4, 0);
    queue_query(32'h0, 32'h0);
    queue_query(20 * UNIT, 32'h0);
    queue_query(-10 * UNIT, 32'h0);
    queue_query(10 * UNIT, 10 * UNIT);
    queue_query(32'h0, 10 * UNIT);
    queue_query(32'h0, -10 * UNIT);
    queue_query(32'h8000_0000, 32'h0);
    queue_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);

    // Triangle spanning the whole coordinate range
    begin_phase(7'd3, 0);
    queue_write(6'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_write(6'd0, 32'h8000_0000, 32'h8000_0000);
    queue_query(32'h0, 32'h0);
    queue_query(32'h7FFF_FFFF, 32'h0);
    queue_query(UNIT, 32'h8000_0001);

    // One vertex and two vertices: degenerate edges
    begin_phase(7'd1, 0);
    queue_query(32'h8000_0000, 32'h8000_0000);
    begin_phase(7'd2, 0);
    queue_query(32'h0, 32'h0);
    queue_query(32'h8000_0000, 32'h7FFF_FFFF);

    // Random polygons across counts and sender idling
    run_phase(7'd5, 0, 60);
    run_phase(7'd64, 84, 60);
    run_phase(7'd127, 84, 45);
    run_phase(7'd3, 35, 60);
    run_phase(7'd16, 84, 50);
    run_phase(7'd65, 0, 45);
    run_phase(7'd0, 35, 25);
    run_phase(7'd8, 0, 70);
    run_phase(7'd1, 84, 25);
    run_phase(7'd33, 35, 75);
    run_phase(7'd4, 0, 45);

    wait_idle();
    repeat (END_WAIT) @(posedge clk);
    if (failures == 0 && expected_inside.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== point_in_polygon_test_unit.f =====
src/pip_pkg.sv
src/pip_vertex_mem.sv
src/pip_edge_pipe.sv
src/point_in_polygon_test_unit.sv
tb/point_in_polygon_test_unit_tb.sv
